### sv/ipv4p_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4p_pkg: shared definitions for the dotted-decimal address parser
// Constants, count widths and the BCD-to-byte conversion.
// ----------------------------------------------------------------------------
package ipv4p_pkg;

    localparam int GROUPS_DEF = 4;

    localparam int CH_W      = 8;
    localparam int ADDR_W    = 32;
    localparam int BYTE_W    = 8;
    localparam int NIB_W     = 4;
    localparam int BCD_W     = 3 * NIB_W;
    localparam int CNT_W     = 3;

    localparam logic [CH_W-1:0]  CH_END      = 8'h00;
    localparam logic [CH_W-1:0]  CH_DIGIT_LO = 8'h30;
    localparam logic [CH_W-1:0]  CH_DIGIT_HI = 8'h39;
    localparam logic [CNT_W-1:0] DIGIT_SAT   = 3'd4;

    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [BCD_W-1:0]  t_bcd;
    typedef logic [ADDR_W-1:0] t_addr;

    // hundreds*100 + tens*10 + units, kept mod 256
    function automatic logic [BYTE_W-1:0] bcd_to_byte(input t_bcd bcd);
        logic [9:0] h;
        logic [9:0] t;
        logic [9:0] u;
        logic [9:0] sum;
        h   = {6'd0, bcd[11:8]};
        t   = {6'd0, bcd[7:4]};
        u   = {6'd0, bcd[3:0]};
        sum = (h * 10'd100) + (t * 10'd10) + u;
        return sum[BYTE_W-1:0];
    endfunction

endpackage
`default_nettype wire

### sv/ipv4_dotted_decimal_parser_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4_dotted_decimal_parser_unit: dotted-decimal string to IPv4 address
//
// Input channel (i_ch_valid / o_ch_ready / i_ch): one character per word.
// A zero character ends the string; only that word produces a result.
// Output channel (o_res_valid / i_res_ready / o_address / o_valid_res):
// one word per string, the address with the first group in the top byte,
// or zero with o_valid_res low unless the first GROUPS groups each had 1-3 digits.
//
// Throughput: one character per cycle while the input is not blocked. The
// result word appears in the cycle after its end-of-string character is taken.
// The parse state (group and digit counters, BCD digits, address
// accumulator) updates in the same cycle a character is taken; the result
// register holds one finished word.
// A stalled receiver blocks the input only while the result register is
// full and not being drained this cycle; the same word is held until taken.
// Reset (synchronous, active low) clears the parse state and the result
// valid flag; no result is pending after reset.
// ----------------------------------------------------------------------------
module ipv4_dotted_decimal_parser_unit #(
    parameter int GROUPS = ipv4p_pkg::GROUPS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_ch_valid,
    output logic                              o_ch_ready,
    input  wire  [ipv4p_pkg::CH_W-1:0]        i_ch,
    output logic                              o_res_valid,
    input  wire                               i_res_ready,
    output logic [ipv4p_pkg::ADDR_W-1:0]      o_address,
    output logic                              o_valid_res
);
    import ipv4p_pkg::*;

    localparam t_cnt GROUPS_C = t_cnt'(GROUPS);

    // parse state
    t_cnt  r_groups_done, n_groups_done;
    t_cnt  r_good_groups, n_good_groups;
    t_cnt  r_digit_count, n_digit_count;
    t_bcd  r_digit_buffer, n_digit_buffer;
    t_addr r_address_acc, n_address_acc;

    // result register
    logic  r_res_valid, n_res_valid;
    t_addr r_address, n_address;
    logic  r_valid_res, n_valid_res;

    logic  ch_take;
    logic  is_end;
    logic  is_digit;
    logic  do_close;
    t_cnt  cl_groups_done;
    t_cnt  cl_good_groups;
    t_addr cl_address_acc;

    // free the result slot when empty or being drained this cycle
    assign o_ch_ready = !r_res_valid || i_res_ready;
    assign ch_take    = i_ch_valid && o_ch_ready;

    assign is_end   = (i_ch == CH_END);
    assign is_digit = (i_ch >= CH_DIGIT_LO) && (i_ch <= CH_DIGIT_HI);

    // group close: count the slot, shift in a byte unless the group was long
    always_comb begin
        cl_groups_done = r_groups_done + t_cnt'(1);
        cl_good_groups = r_good_groups;
        cl_address_acc = r_address_acc;
        if (r_digit_count < DIGIT_SAT) begin
            cl_good_groups = r_good_groups + t_cnt'(1);
            cl_address_acc = {r_address_acc[ADDR_W-BYTE_W-1:0], bcd_to_byte(r_digit_buffer)};
        end
    end

    always_comb begin
        n_groups_done  = r_groups_done;
        n_good_groups  = r_good_groups;
        n_digit_count  = r_digit_count;
        n_digit_buffer = r_digit_buffer;
        n_address_acc  = r_address_acc;
        n_res_valid    = r_res_valid && !i_res_ready;
        n_address      = r_address;
        n_valid_res    = r_valid_res;
        do_close       = 1'b0;

        if (ch_take) begin
            if (is_end) begin
                // close an open group if a slot is left, then emit and clear
                do_close = (r_groups_done < GROUPS_C) && (r_digit_count != '0);
                n_res_valid = 1'b1;
                if (do_close) begin
                    n_valid_res = (cl_good_groups == GROUPS_C);
                    n_address   = n_valid_res ? cl_address_acc : '0;
                end else begin
                    n_valid_res = (r_good_groups == GROUPS_C);
                    n_address   = n_valid_res ? r_address_acc : '0;
                end
                n_groups_done  = '0;
                n_good_groups  = '0;
                n_digit_count  = '0;
                n_digit_buffer = '0;
                n_address_acc  = '0;
            end else if (r_groups_done < GROUPS_C) begin
                if (is_digit) begin
                    // shift in the BCD digit, saturate the count
                    n_digit_buffer = {r_digit_buffer[BCD_W-NIB_W-1:0],
                                      NIB_W'(i_ch - CH_DIGIT_LO)};
                    if (r_digit_count < DIGIT_SAT) begin
                        n_digit_count = r_digit_count + t_cnt'(1);
                    end
                end else if (r_digit_count != '0) begin
                    n_groups_done  = cl_groups_done;
                    n_good_groups  = cl_good_groups;
                    n_address_acc  = cl_address_acc;
                    n_digit_count  = '0;
                    n_digit_buffer = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_groups_done  <= '0;
            r_good_groups  <= '0;
            r_digit_count  <= '0;
            r_digit_buffer <= '0;
            r_address_acc  <= '0;
            r_res_valid    <= 1'b0;
        end else begin
            r_groups_done  <= n_groups_done;
            r_good_groups  <= n_good_groups;
            r_digit_count  <= n_digit_count;
            r_digit_buffer <= n_digit_buffer;
            r_address_acc  <= n_address_acc;
            r_res_valid    <= n_res_valid;
        end
    end

    // result payload: hold while the receiver stalls
    always_ff @(posedge i_clk) begin
        r_address   <= n_address;
        r_valid_res <= n_valid_res;
    end

    assign o_res_valid = r_res_valid;
    assign o_address   = r_address;
    assign o_valid_res = r_valid_res;

endmodule
`default_nettype wire
